/* design/brs_pkg.sv */
`timescale 1ns / 1ps
// Package for the byte randomness statistics core.
// Holds the result record type and fixed constants; depends on nothing.
package brs_pkg;

   // Depth of the result queue, which also bounds the marked bytes in flight.
   localparam int unsigned RESULT_DEPTH = 8;
   localparam int unsigned RESULT_PTR_BITS = 3;

   typedef struct packed {
      logic [31:0] byte_count;
      logic [39:0] byte_sum;
      logic [47:0] square_sum;
      logic [47:0] lag_product_sum;
      logic [29:0] mc_points;
      logic [29:0] mc_hits;
      logic [31:0] run_count;
      logic [39:0] abs_delta_sum;
      logic [63:0] freq_square_sum;
      logic [8:0]  distinct_count;
      logic [7:0]  min_value;
      logic [7:0]  max_value;
   } result_type;

endpackage

/* design/byte_randomness_statistics_core.sv */
`timescale 1ns / 1ps
// Byte randomness statistics core: histogram in a 256-entry synchronous memory plus sums.
// A byte marked last shows its result after its bin update stage, two snapshot stages
// and the write into the result queue.
// Throughput: one byte per cycle, set by the single histogram read-modify-write, which
// forwards the bin written in the same cycle; the input stalls only while eight results
// are owed. Reset: synchronous; clears the histogram valid bits, sums and queue at once.
module byte_randomness_statistics_core
   import brs_pkg::*;
#(
   parameter int unsigned COUNT_BITS  = 32,
   parameter int unsigned COORD_BYTES = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_byte_count,
   output logic [39:0] rsp_byte_sum,
   output logic [47:0] rsp_square_sum,
   output logic [47:0] rsp_lag_product_sum,
   output logic [29:0] rsp_mc_points,
   output logic [29:0] rsp_mc_hits,
   output logic [31:0] rsp_run_count,
   output logic [39:0] rsp_abs_delta_sum,
   output logic [63:0] rsp_freq_square_sum,
   output logic [8:0]  rsp_distinct_count,
   output logic [7:0]  rsp_min_value,
   output logic [7:0]  rsp_max_value
);

   localparam int unsigned CB          = COUNT_BITS;
   localparam int unsigned COORD_BITS  = 8 * COORD_BYTES;
   localparam int unsigned POINT_BYTES = 2 * COORD_BYTES;
   localparam int unsigned FSQ_BITS    = 2 * COUNT_BITS;

   // The histogram itself. Each bin has a valid bit in flops so that the end of a
   // stream empties all bins at once; a bin without its valid bit reads as zero.
   logic [CB-1:0] hist_mem [256];
   logic [255:0]  bin_valid_ff;

   logic          s1_valid_ff;
   logic [7:0]    s1_byte_ff;
   logic          s1_last_ff;
   logic          s1_fwd_ff;
   logic [CB-1:0] s1_fwd_value_ff;
   logic          s1_fresh_ff;
   logic [CB-1:0] hist_rd_ff;
   logic          bin_valid_rd_ff;

   logic          req_xfer, rsp_xfer;
   logic [CB-1:0] bin_count, bin_count_next;

   // Running sums of the current stream.
   logic [CB-1:0]        count_ff, count_in;
   logic [CB+7:0]        sum_ff, sum_in;
   logic [CB+15:0]       square_ff, square_in;
   logic [CB+15:0]       lag_ff, lag_in;
   logic [CB+7:0]        delta_ff, delta_in;
   logic [CB-1:0]        runs_ff, runs_in;
   logic [7:0]           first_ff, first_in;
   logic [7:0]           prev_ff, prev_in;
   logic [2:0]           phase_ff, phase_in;
   logic [COORD_BITS-1:0] coord_x_ff, coord_x_in, coord_y_ff, coord_y_in;
   logic [CB-3:0]        points_ff, points_in;
   logic [CB-3:0]        hits_ff, hits_in;
   logic [FSQ_BITS-1:0]  fsq_ff, fsq_in;
   logic [8:0]           distinct_ff, distinct_in;
   logic [7:0]           min_ff, min_in, max_ff, max_in;

   logic [7:0]    cur_byte, byte_delta, lag_first;
   logic [CB+15:0] lag_step;
   logic          point_done;
   logic          hit_valid, hit;

   result_type    snap2_ff, snap2_in, snap3_ff, fifo_entry;
   logic          snap2_valid_ff, snap3_valid_ff;

   result_type    fifo_mem [RESULT_DEPTH];
   logic [RESULT_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RESULT_PTR_BITS:0]   fill_ff, fill_in;
   logic [RESULT_PTR_BITS:0]   pending_ff, pending_in;

   assign req_ready = (pending_ff != (RESULT_PTR_BITS + 1)'(RESULT_DEPTH));
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = (fill_ff != '0);
   assign rsp_xfer  = rsp_valid && rsp_ready;

   // Bin lookup with forwarding: the byte just ahead writes its bin on the same
   // edge that this byte read it, so a matching address takes the fresh count.
   // A byte that follows a marked last byte starts with an empty histogram.
   always_comb begin
      if (s1_fwd_ff) begin
         bin_count = s1_fwd_value_ff;
      end else if (s1_fresh_ff || !bin_valid_rd_ff) begin
         bin_count = '0;
      end else begin
         bin_count = hist_rd_ff;
      end
      bin_count_next = bin_count + CB'(1);
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         hist_mem[s1_byte_ff] <= bin_count_next;
      end
      hist_rd_ff      <= hist_mem[req_data_byte];
      bin_valid_rd_ff <= bin_valid_ff[req_data_byte];
      s1_byte_ff      <= req_data_byte;
      s1_last_ff      <= req_last;
      s1_fwd_ff       <= s1_valid_ff && !s1_last_ff && (s1_byte_ff == req_data_byte);
      s1_fwd_value_ff <= bin_count_next;
      s1_fresh_ff     <= s1_valid_ff && s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         bin_valid_ff <= '0;
      end else begin
         s1_valid_ff <= req_xfer;
         if (s1_valid_ff && s1_last_ff) begin
            bin_valid_ff <= '0;
         end else if (s1_valid_ff) begin
            bin_valid_ff[s1_byte_ff] <= 1'b1;
         end
      end
   end

   // Per-byte update of the running sums other than the hit count, in the same stage as the bin update.
   always_comb begin
      cur_byte   = s1_byte_ff;
      byte_delta = (cur_byte > prev_ff) ? (cur_byte - prev_ff) : (prev_ff - cur_byte);

      count_in    = count_ff;
      sum_in      = sum_ff;
      square_in   = square_ff;
      lag_in      = lag_ff;
      delta_in    = delta_ff;
      runs_in     = runs_ff;
      first_in    = first_ff;
      prev_in     = prev_ff;
      phase_in    = phase_ff;
      coord_x_in  = coord_x_ff;
      coord_y_in  = coord_y_ff;
      points_in   = points_ff;
      fsq_in      = fsq_ff;
      distinct_in = distinct_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      point_done  = 1'b0;
      lag_first   = first_ff;

      if (s1_valid_ff) begin
         if (count_ff == '0) begin
            first_in  = cur_byte;
            lag_first = cur_byte;
            runs_in   = runs_ff + CB'(1);
         end else begin
            lag_in   = lag_ff + (CB + 16)'({8'd0, prev_ff} * {8'd0, cur_byte});
            delta_in = delta_ff + (CB + 8)'(byte_delta);
            if (cur_byte != prev_ff) begin
               runs_in = runs_ff + CB'(1);
            end
         end
         prev_in = cur_byte;

         if (bin_count == '0) begin
            distinct_in = distinct_ff + 9'd1;
         end
         fsq_in = fsq_ff + FSQ_BITS'({bin_count, 1'b1});

         count_in  = count_ff + CB'(1);
         sum_in    = sum_ff + (CB + 8)'(cur_byte);
         square_in = square_ff + (CB + 16)'({8'd0, cur_byte} * {8'd0, cur_byte});
         if (cur_byte < min_ff) begin
            min_in = cur_byte;
         end
         if (cur_byte > max_ff) begin
            max_in = cur_byte;
         end

         // Coordinates arrive most significant byte first, x then y.
         if (phase_ff < 3'(COORD_BYTES)) begin
            coord_x_in = (coord_x_ff << 8) | COORD_BITS'(cur_byte);
         end else begin
            coord_y_in = (coord_y_ff << 8) | COORD_BITS'(cur_byte);
         end
         if (phase_ff == 3'(POINT_BYTES - 1)) begin
            phase_in   = '0;
            points_in  = points_ff + (CB - 2)'(1);
            point_done = 1'b1;
         end else begin
            phase_in = phase_ff + 3'd1;
         end
      end

      lag_step = lag_in + (CB + 16)'({8'd0, cur_byte} * {8'd0, lag_first});

      snap2_in.byte_count      = 32'(count_in);
      snap2_in.byte_sum        = 40'(sum_in);
      snap2_in.square_sum      = 48'(square_in);
      snap2_in.lag_product_sum = 48'(lag_step);
      snap2_in.mc_points       = 30'(points_in);
      snap2_in.mc_hits         = '0;
      snap2_in.run_count       = 32'(runs_in);
      snap2_in.abs_delta_sum   = 40'(delta_in);
      snap2_in.freq_square_sum = 64'(fsq_in);
      snap2_in.distinct_count  = distinct_in;
      snap2_in.min_value       = min_in;
      snap2_in.max_value       = max_in;
   end

   brs_mc_hit #(
      .COORD_BITS (COORD_BITS)
   ) u_mc_hit (
      .clock     (clock),
      .reset     (reset),
      .pt_valid  (point_done),
      .pt_x      (coord_x_in),
      .pt_y      (coord_y_in),
      .hit_valid (hit_valid),
      .hit       (hit)
   );

   // Hits land after the squaring and compare registers of the hit test; the marked byte's record travels
   // alongside so that its hit count includes its own final point.
   always_comb begin
      hits_in = hits_ff;
      if (hit_valid && hit) begin
         hits_in = hits_ff + (CB - 2)'(1);
      end
      fifo_entry         = snap3_ff;
      fifo_entry.mc_hits = 30'(hits_in);
   end

   always_ff @(posedge clock) begin
      if (reset || (s1_valid_ff && s1_last_ff)) begin
         count_ff    <= '0;
         sum_ff      <= '0;
         square_ff   <= '0;
         lag_ff      <= '0;
         delta_ff    <= '0;
         runs_ff     <= '0;
         first_ff    <= '0;
         prev_ff     <= '0;
         phase_ff    <= '0;
         coord_x_ff  <= '0;
         coord_y_ff  <= '0;
         points_ff   <= '0;
         fsq_ff      <= '0;
         distinct_ff <= '0;
         min_ff      <= 8'hFF;
         max_ff      <= '0;
      end else begin
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         square_ff   <= square_in;
         lag_ff      <= lag_in;
         delta_ff    <= delta_in;
         runs_ff     <= runs_in;
         first_ff    <= first_in;
         prev_ff     <= prev_in;
         phase_ff    <= phase_in;
         coord_x_ff  <= coord_x_in;
         coord_y_ff  <= coord_y_in;
         points_ff   <= points_in;
         fsq_ff      <= fsq_in;
         distinct_ff <= distinct_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
      end
   end

   always_comb begin
      fill_in    = fill_ff;
      pending_in = pending_ff;
      if (snap3_valid_ff && !rsp_xfer) begin
         fill_in = fill_ff + (RESULT_PTR_BITS + 1)'(1);
      end else if (!snap3_valid_ff && rsp_xfer) begin
         fill_in = fill_ff - (RESULT_PTR_BITS + 1)'(1);
      end
      if (req_xfer && req_last && !rsp_xfer) begin
         pending_in = pending_ff + (RESULT_PTR_BITS + 1)'(1);
      end else if (!(req_xfer && req_last) && rsp_xfer) begin
         pending_in = pending_ff - (RESULT_PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff        <= '0;
         snap2_valid_ff <= 1'b0;
         snap3_valid_ff <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         fill_ff        <= '0;
         pending_ff     <= '0;
      end else begin
         hits_ff        <= snap3_valid_ff ? '0 : hits_in;
         snap2_valid_ff <= s1_valid_ff && s1_last_ff;
         snap3_valid_ff <= snap2_valid_ff;
         if (snap3_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + RESULT_PTR_BITS'(1);
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + RESULT_PTR_BITS'(1);
         end
         fill_ff    <= fill_in;
         pending_ff <= pending_in;
      end
      snap2_ff <= snap2_in;
      snap3_ff <= snap2_ff;
      if (snap3_valid_ff) begin
         fifo_mem[wr_ptr_ff] <= fifo_entry;
      end
   end

   assign rsp_byte_count      = fifo_mem[rd_ptr_ff].byte_count;
   assign rsp_byte_sum        = fifo_mem[rd_ptr_ff].byte_sum;
   assign rsp_square_sum      = fifo_mem[rd_ptr_ff].square_sum;
   assign rsp_lag_product_sum = fifo_mem[rd_ptr_ff].lag_product_sum;
   assign rsp_mc_points       = fifo_mem[rd_ptr_ff].mc_points;
   assign rsp_mc_hits         = fifo_mem[rd_ptr_ff].mc_hits;
   assign rsp_run_count       = fifo_mem[rd_ptr_ff].run_count;
   assign rsp_abs_delta_sum   = fifo_mem[rd_ptr_ff].abs_delta_sum;
   assign rsp_freq_square_sum = fifo_mem[rd_ptr_ff].freq_square_sum;
   assign rsp_distinct_count  = fifo_mem[rd_ptr_ff].distinct_count;
   assign rsp_min_value       = fifo_mem[rd_ptr_ff].min_value;
   assign rsp_max_value       = fifo_mem[rd_ptr_ff].max_value;

endmodule

/* design/brs_mc_hit.sv */
`timescale 1ns / 1ps
// Two-stage Monte Carlo point test: squares the coordinates, then compares.
// Depends on nothing but its parameter.
module brs_mc_hit #(
   parameter int unsigned COORD_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pt_valid,
   input  logic [COORD_BITS-1:0] pt_x,
   input  logic [COORD_BITS-1:0] pt_y,
   output logic                  hit_valid,
   output logic                  hit
);

   localparam int unsigned SQ_BITS  = 2 * COORD_BITS;
   localparam int unsigned SUM_BITS = SQ_BITS + 1;
   localparam logic [SUM_BITS-1:0] MAX_COORD = SUM_BITS'({COORD_BITS{1'b1}});
   localparam logic [SUM_BITS-1:0] RADIUS_SQ = MAX_COORD * MAX_COORD;

   logic                  sq_valid_ff, sq_valid_in;
   logic [SQ_BITS-1:0]    sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic                  hit_valid_ff, hit_valid_in;
   logic                  hit_ff, hit_in;
   logic [SUM_BITS-1:0]   sq_total;

   always_comb begin
      sq_valid_in  = pt_valid;
      sq_x_in      = SQ_BITS'(pt_x) * SQ_BITS'(pt_x);
      sq_y_in      = SQ_BITS'(pt_y) * SQ_BITS'(pt_y);
      sq_total     = SUM_BITS'(sq_x_ff) + SUM_BITS'(sq_y_ff);
      hit_valid_in = sq_valid_ff;
      hit_in       = (sq_total <= RADIUS_SQ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         hit_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff  <= sq_valid_in;
         hit_valid_ff <= hit_valid_in;
      end
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      hit_ff  <= hit_in;
   end

   assign hit_valid = hit_valid_ff;
   assign hit       = hit_ff;

endmodule

/* design/brs_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the byte randomness statistics core, with its bind.
// Depends on byte_randomness_statistics_core.
module brs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_byte_count,
   input logic [8:0]  rsp_distinct_count,
   input logic [7:0]  rsp_min_value,
   input logic [7:0]  rsp_max_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_count))
      else $error("stalled result transfer changed or dropped");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_min_value <= rsp_max_value)
      else $error("minimum above maximum");

   a_distinct: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_distinct_count != 9'd0 && rsp_distinct_count <= 9'd256)
      else $error("distinct count out of range");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind byte_randomness_statistics_core brs_checker u_brs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_byte_count     (rsp_byte_count),
   .rsp_distinct_count (rsp_distinct_count),
   .rsp_min_value      (rsp_min_value),
   .rsp_max_value      (rsp_max_value)
);
